[src/sfh32_pkg.sv]
`timescale 1ns / 1ps

package sfh32_pkg;

  // Hash and field widths
  localparam int HASH_W  = 32;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 3;
  localparam int LEN_W   = 31;

  // Stream data layout: word, byte_count, total_length, padded to bytes
  localparam int TDATA_FIELDS_W = WORD_W + COUNT_W + LEN_W;
  localparam int TDATA_W        = ((TDATA_FIELDS_W + 7) / 8) * 8;
  localparam int COUNT_LSB      = WORD_W;
  localparam int LEN_LSB        = WORD_W + COUNT_W;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Tail byte counts
  localparam logic [1:0] TAIL_ONE   = 2'd1;
  localparam logic [1:0] TAIL_TWO   = 2'd2;
  localparam logic [1:0] TAIL_THREE = 2'd3;

  // One finished message handed from front to back
  typedef struct packed {
    logic [HASH_W-1:0] hash;   // mixed hash before avalanche
    logic              empty;  // last beat carried no bytes
  } sfh32_entry_t;

endpackage

[src/sfh32_front.sv]
`timescale 1ns / 1ps

module sfh32_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [sfh32_pkg::HASH_W-1:0]        cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [sfh32_pkg::WORD_W-1:0]        word,
  input  logic [sfh32_pkg::COUNT_W-1:0]       byte_count,
  input  logic                                first,
  input  logic                                last,
  input  logic [sfh32_pkg::LEN_W-1:0]         total_length,
  output logic                                push,
  output sfh32_pkg::sfh32_entry_t             push_entry
);

  logic [sfh32_pkg::HASH_W-1:0] seed;
  logic [sfh32_pkg::HASH_W-1:0] running_hash;
  logic [sfh32_pkg::HASH_W-1:0] h_base;
  logic [sfh32_pkg::HASH_W-1:0] h_next;
  logic                         accept;

  function automatic logic [31:0] sext8(input logic [7:0] b);
    sext8 = {{24{b[7]}}, b};
  endfunction

  function automatic logic [31:0] mix_full(input logic [31:0] h, input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] m;
    a = h + {16'd0, w[15:0]};
    m = {a[15:0], 16'd0} ^ {5'd0, w[31:16], 11'd0} ^ a;
    mix_full = m + (m >> 11);
  endfunction

  function automatic logic [31:0] mix_tail(input logic [31:0] h, input logic [31:0] w,
                                           input logic [1:0] n);
    logic [31:0] a;
    a = h;
    case (n)
      sfh32_pkg::TAIL_THREE: begin
        a = h + {16'd0, w[15:0]};
        a = a ^ (a << 16);
        a = a ^ (sext8(w[23:16]) << 18);
        a = a + (a >> 11);
      end
      sfh32_pkg::TAIL_TWO: begin
        a = h + {16'd0, w[15:0]};
        a = a ^ (a << 11);
        a = a + (a >> 17);
      end
      sfh32_pkg::TAIL_ONE: begin
        a = h + sext8(w[7:0]);
        a = a ^ (a << 10);
        a = a + (a >> 1);
      end
      default: a = h;
    endcase
    mix_tail = a;
  endfunction

  assign accept = in_valid && in_ready;

  // Pick the starting hash (seed, length, or carried value) and mix in the word
  always_comb begin
    if (first) begin
      h_base = (seed != '0) ? seed : {1'b0, total_length};
    end else begin
      h_base = running_hash;
    end
    if (byte_count[2]) begin
      h_next = mix_full(h_base, word);
    end else begin
      h_next = mix_tail(h_base, word, byte_count[1:0]);
    end
  end

  // Hand finished messages to the queue
  assign push             = accept && last;
  assign push_entry.hash  = h_next;
  assign push_entry.empty = (byte_count == '0);

  // Hold seed and running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      seed         <= '0;
      running_hash <= '0;
    end else begin
      if (cfg_valid) begin
        seed <= cfg_data;
      end
      if (accept) begin
        running_hash <= h_next;
      end
    end
  end

endmodule

[src/sfh32_queue.sv]
`timescale 1ns / 1ps

module sfh32_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  sfh32_pkg::sfh32_entry_t push_entry,
  output logic                    not_full,
  input  logic                    pop,
  output logic                    head_valid,
  output sfh32_pkg::sfh32_entry_t head_entry
);

  sfh32_pkg::sfh32_entry_t             slots [sfh32_pkg::Q_DEPTH];
  logic [sfh32_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [sfh32_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [sfh32_pkg::Q_CNT_W-1:0]       count;

  assign not_full   = (count != sfh32_pkg::Q_CNT_W'(sfh32_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sfh32_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfh32_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sfh32_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sfh32_pkg::Q_CNT_W'(1);
      end
    end
  end

endmodule

[src/sfh32_back.sv]
`timescale 1ns / 1ps

module sfh32_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  sfh32_pkg::sfh32_entry_t       head_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sfh32_pkg::HASH_W-1:0]  out_hash
);

  logic                         st1_valid;
  logic [sfh32_pkg::HASH_W-1:0] st1_hash;
  logic                         st1_empty;
  logic [sfh32_pkg::HASH_W-1:0] a1;
  logic [sfh32_pkg::HASH_W-1:0] a2;
  logic                         out_free;
  logic                         adv1;

  // First half of the avalanche
  always_comb begin
    a1 = head_entry.hash ^ (head_entry.hash << 3);
    a1 = a1 + (a1 >> 5);
    a1 = a1 ^ (a1 << 4);
  end

  // Second half of the avalanche
  always_comb begin
    a2 = st1_hash + (st1_hash >> 17);
    a2 = a2 ^ (a2 << 25);
    a2 = a2 + (a2 >> 6);
  end

  assign out_free = !out_valid || out_ready;
  assign adv1     = st1_valid && out_free;
  assign pop      = head_valid && (!st1_valid || adv1);

  // Advance the two stages, stall on the output
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!st1_valid || adv1) begin
        st1_valid <= head_valid;
      end
      if (out_free) begin
        out_valid <= st1_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      st1_hash  <= a1;
      st1_empty <= head_entry.empty;
    end
    if (adv1) begin
      out_hash <= st1_empty ? '0 : a2;
    end
  end

endmodule

[src/super_fast_hash_32.sv]
`timescale 1ns / 1ps

// Channel  | Direction | Beat carries
// ---------+-----------+------------------------------------------------------
// s_*      | in        | tdata: word, byte_count, total_length; tuser: first;
//          |           | tlast: last
// m_*      | out       | tdata: hash, one beat per message
// cfg_*    | in        | data: seed register
//
// One word beat is taken every cycle while s_tready is high; the running-hash
// update in the front is combinational and held in the running_hash register.
// A hash passes through a queue slot, the first avalanche stage and the output
// register before it is valid. Synchronous active-high reset clears seed,
// running hash, queue and stage valid bits. s_tready drops only when the
// four-entry queue is full because m_tready is held low; cfg_ready is always high.

module super_fast_hash_32 (
  input  logic                            clk,
  input  logic                            rst,
  // Seed write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sfh32_pkg::HASH_W-1:0]    cfg_data,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] word, [34:32] byte_count, [65:35] total_length, [71:66] zero
  input  logic [sfh32_pkg::TDATA_W-1:0]   s_tdata,
  // [0] first
  input  logic [0:0]                      s_tuser,
  input  logic                            s_tlast,
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [31:0] hash
  output logic [sfh32_pkg::HASH_W-1:0]    m_tdata
);

  logic                    push;
  logic                    not_full;
  logic                    pop;
  logic                    head_valid;
  sfh32_pkg::sfh32_entry_t push_entry;
  sfh32_pkg::sfh32_entry_t head_entry;

  assign cfg_ready = 1'b1;
  assign s_tready  = not_full;

  sfh32_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .word         (s_tdata[sfh32_pkg::WORD_W-1:0]),
    .byte_count   (s_tdata[sfh32_pkg::COUNT_LSB +: sfh32_pkg::COUNT_W]),
    .first        (s_tuser[0]),
    .last         (s_tlast),
    .total_length (s_tdata[sfh32_pkg::LEN_LSB +: sfh32_pkg::LEN_W]),
    .push         (push),
    .push_entry   (push_entry)
  );

  sfh32_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  sfh32_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_hash   (m_tdata)
  );

endmodule
